>>> src/hdrtm_pkg.sv
// shared constants, types and the byte log table of the hdr tone map pixel block
package hdrtm_pkg;

	localparam int IDX_W         = 22;
	localparam int CHAN_W        = 24;
	localparam int FRACTION_BITS = 16;
	localparam int LOG_FRAC      = 24;
	localparam int MANT_BITS     = 30;
	localparam int LOG_IN_W      = CHAN_W + 1;
	localparam int POS_W         = 5;
	localparam int LOG_W         = POS_W + LOG_FRAC;
	localparam int GAMMA_W       = 11;
	localparam logic [GAMMA_W-1:0] GAMMA_RESET = 11'd563;
	localparam int BYTE_W        = 8;

	localparam int DIV_W         = 40;
	localparam int DIV_STEP      = 4;
	localparam int DIV_STAGES    = DIV_W / DIV_STEP;
	localparam int SEARCH_STAGES = BYTE_W;
	localparam int LOG_STAGES    = LOG_FRAC + 1;

	// stage map of one channel
	localparam int ST_MAG     = LOG_STAGES;
	localparam int ST_DIV0    = ST_MAG + 1;
	localparam int ST_SRCH0   = ST_DIV0 + DIV_STAGES;
	localparam int NUM_STAGES = ST_SRCH0 + SEARCH_STAGES;

	// register index decode (paddr[2])
	localparam logic REG_GAMMA = 1'b0;

	typedef logic [NUM_STAGES-1:0] stage_en_t;
	typedef logic [LOG_W-1:0] log_tab_t [256];

	// log2 in Q.24, same squaring steps as the datapath
	function automatic logic [LOG_W-1:0] log2_q24(input logic [31:0] x);
		logic [63:0] m;
		logic [63:0] r;
		int pos;
		pos = 0;
		for (int b = 0; b < 32; b++)
			if (x[b]) pos = b;
		m = 64'(x) << (MANT_BITS - pos);
		r = 64'(pos) << LOG_FRAC;
		for (int i = LOG_FRAC - 1; i >= 0; i--) begin
			m = (m * m) >> MANT_BITS;
			if (m >= (64'd2 << MANT_BITS)) begin
				m = m >> 1;
				r = r | (64'd1 << i);
			end
		end
		return r[LOG_W-1:0];
	endfunction

	function automatic log_tab_t build_log_tab();
		log_tab_t t;
		for (int k = 0; k < 256; k++)
			t[k] = (k == 0) ? '0 : log2_q24(32'(k));
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();
	localparam logic [LOG_W-1:0] LOG_LIM = LOG_TAB[255];

endpackage

>>> src/hdr_tone_map_gamma_pixel_top.sv
// top level of the hdr tone map and gamma pixel block
//
// usage
// - input stream s_*: one hdr pixel per transfer, index and three Q8.16
//   linear channels packed in s_tdata
// - output stream m_*: one transfer per pixel, index and three display bytes
// - apb port: register 0 (byte address 0) is gamma, unsigned Q3.8, reset 563;
//   write only while no pixel is in flight
// - pipeline: 44 register stages (25 log stages, 1 difference stage,
//   10 divider stages, 8 search stages)
// - throughput: one pixel per cycle while m_tready stays high, set by the fully pipelined datapath
// - each stage holds its own valid bit; a stage loads when it is empty or
//   the stage after it moves, so bubbles are squeezed out during a stall
// - when m_tready is low the pipeline fills up and then s_tready drops;
//   nothing is lost or repeated
// - reset clears all valid bits and restores gamma; alpha (255) is left
//   to the consumer
module hdr_tone_map_gamma_pixel_top import hdrtm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // pixel_index, red_in, green_in, blue_in
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // pixel_index_out, red_out, green_out, blue_out
);

	logic [GAMMA_W-1:0] gamma_q;
	logic [GAMMA_W-1:0] den;
	stage_en_t          en;
	logic [NUM_STAGES-1:0] vld_s;
	logic [IDX_W-1:0]   idx_s [NUM_STAGES];
	logic [BYTE_W-1:0]  red_b;
	logic [BYTE_W-1:0]  green_b;
	logic [BYTE_W-1:0]  blue_b;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_GAMMA) begin
			gamma_q <= pwdata[GAMMA_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_GAMMA) ? 32'(gamma_q) : '0;

	// code zero acts as the steepest exponent
	assign den = (gamma_q == '0) ? GAMMA_W'(1) : gamma_q;

	// stage enables: load when empty or when the next stage moves
	always_comb begin
		en[NUM_STAGES-1] = ~vld_s[NUM_STAGES-1] | m_tready;
		for (int i = NUM_STAGES - 2; i >= 0; i--)
			en[i] = ~vld_s[i] | en[i+1];
	end

	assign s_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = 0; i < NUM_STAGES; i++)
				if (en[i])
					vld_s[i] <= (i == 0) ? s_tvalid : vld_s[(i == 0) ? 0 : i-1];
		end
	end

	// pixel index travels alongside the channels
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_STAGES; i++)
			if (en[i])
				idx_s[i] <= (i == 0) ? s_tdata[IDX_W-1:0] : idx_s[(i == 0) ? 0 : i-1];
	end

	hdrtm_chan u_red (
		.clk      (clk),
		.en       (en),
		.c        (s_tdata[IDX_W +: CHAN_W]),
		.den      (den),
		.byte_out (red_b)
	);

	hdrtm_chan u_green (
		.clk      (clk),
		.en       (en),
		.c        (s_tdata[IDX_W + CHAN_W +: CHAN_W]),
		.den      (den),
		.byte_out (green_b)
	);

	hdrtm_chan u_blue (
		.clk      (clk),
		.en       (en),
		.c        (s_tdata[IDX_W + 2*CHAN_W +: CHAN_W]),
		.den      (den),
		.byte_out (blue_b)
	);

	assign m_tvalid = vld_s[NUM_STAGES-1];
	assign m_tdata  = {2'b00, blue_b, green_b, red_b, idx_s[NUM_STAGES-1]};

endmodule

>>> src/hdrtm_log2.sv
// pipelined base-2 logarithm, one squaring per stage after the normalization stage
module hdrtm_log2 import hdrtm_pkg::*; (
	input  logic                  clk,
	input  logic [LOG_STAGES-1:0] en,
	input  logic [LOG_IN_W-1:0]   x,
	output logic [LOG_W-1:0]      r
);

	logic [POS_W-1:0]     pos;
	logic [MANT_BITS:0]   mant0;
	logic [MANT_BITS:0]   mant_s [LOG_STAGES];
	logic [LOG_W-1:0]     res_s  [LOG_STAGES];

	// leading one and normalization to Q1.30
	always_comb begin
		pos = '0;
		for (int b = 0; b < LOG_IN_W; b++)
			if (x[b]) pos = POS_W'(b);
		mant0 = (MANT_BITS+1)'(x) << (POS_W'(MANT_BITS) - pos);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mant_s[0] <= mant0;
			res_s[0]  <= {pos, LOG_FRAC'(0)};
		end
	end

	for (genvar i = 1; i < LOG_STAGES; i++) begin : g_sq
		logic [2*MANT_BITS+1:0] prod;
		logic [MANT_BITS+1:0]   sq;
		always_comb begin
			prod = mant_s[i-1] * mant_s[i-1];
			sq   = prod[2*MANT_BITS+1:MANT_BITS];
		end
		always_ff @(posedge clk) begin
			if (en[i]) begin
				if (sq[MANT_BITS+1]) begin
					mant_s[i] <= sq[MANT_BITS+1:1];
					res_s[i]  <= res_s[i-1] | (LOG_W'(1) << (LOG_FRAC - i));
				end else begin
					mant_s[i] <= sq[MANT_BITS:0];
					res_s[i]  <= res_s[i-1];
				end
			end
		end
	end

	assign r = res_s[LOG_STAGES-1];

endmodule

>>> src/hdrtm_div.sv
// pipelined restoring divider, four quotient bits per stage
module hdrtm_div import hdrtm_pkg::*; (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  logic [DIV_W-1:0]      num,
	input  logic [GAMMA_W-1:0]    den,
	output logic [DIV_W-1:0]      quo
);

	logic [GAMMA_W-1:0] rem_s [DIV_STAGES];
	logic [DIV_W-1:0]   nq_s  [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		logic [GAMMA_W-1:0] rem_in;
		logic [DIV_W-1:0]   nq_in;
		logic [GAMMA_W-1:0] rem_nx;
		logic [DIV_W-1:0]   nq_nx;
		logic [GAMMA_W:0]   trial;
		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = num;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign nq_in  = nq_s[i-1];
		end
		always_comb begin
			rem_nx = rem_in;
			nq_nx  = nq_in;
			trial  = '0;
			for (int b = 0; b < DIV_STEP; b++) begin
				trial = {rem_nx, nq_nx[DIV_W-1]};
				nq_nx = nq_nx << 1;
				if (trial >= {1'b0, den}) begin
					trial    = trial - {1'b0, den};
					nq_nx[0] = 1'b1;
				end
				rem_nx = trial[GAMMA_W-1:0];
			end
		end
		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_s[i] <= rem_nx;
				nq_s[i]  <= nq_nx;
			end
		end
	end

	assign quo = nq_s[DIV_STAGES-1];

endmodule

>>> src/hdrtm_search.sv
// bitwise search of the largest byte whose log plus y stays at or below the limit
module hdrtm_search import hdrtm_pkg::*; (
	input  logic                     clk,
	input  logic [SEARCH_STAGES-1:0] en,
	input  logic [DIV_W-1:0]         y,
	output logic [BYTE_W-1:0]        k
);

	logic [BYTE_W-1:0] k_s [SEARCH_STAGES];
	logic [DIV_W-1:0]  y_s [SEARCH_STAGES];

	for (genvar j = 0; j < SEARCH_STAGES; j++) begin : g_bit
		logic [BYTE_W-1:0] k_in;
		logic [DIV_W-1:0]  y_in;
		logic [BYTE_W-1:0] cand;
		logic [DIV_W:0]    sum;
		if (j == 0) begin : g_first
			assign k_in = '0;
			assign y_in = y;
		end else begin : g_next
			assign k_in = k_s[j-1];
			assign y_in = y_s[j-1];
		end
		always_comb begin
			cand = k_in | (BYTE_W'(1) << (BYTE_W - 1 - j));
			sum  = (DIV_W+1)'(LOG_TAB[cand]) + (DIV_W+1)'(y_in);
		end
		always_ff @(posedge clk) begin
			if (en[j]) begin
				k_s[j] <= (sum <= (DIV_W+1)'(LOG_LIM)) ? cand : k_in;
				y_s[j] <= y_in;
			end
		end
	end

	assign k = k_s[SEARCH_STAGES-1];

endmodule

>>> src/hdrtm_chan.sv
// one color channel: tone map log ratio, gamma scaling and byte search
module hdrtm_chan import hdrtm_pkg::*; (
	input  logic               clk,
	input  stage_en_t          en,
	input  logic [CHAN_W-1:0]  c,
	input  logic [GAMMA_W-1:0] den,
	output logic [BYTE_W-1:0]  byte_out
);

	logic [LOG_W-1:0]   lnum;
	logic [LOG_W-1:0]   lden;
	logic [LOG_W-1:0]   mag_s;
	logic [DIV_W-1:0]   y;
	logic [BYTE_W-1:0]  k;
	logic               zero_s [NUM_STAGES];

	hdrtm_log2 u_log_num (
		.clk (clk),
		.en  (en[LOG_STAGES-1:0]),
		.x   (LOG_IN_W'(c)),
		.r   (lnum)
	);

	hdrtm_log2 u_log_den (
		.clk (clk),
		.en  (en[LOG_STAGES-1:0]),
		.x   (LOG_IN_W'(c) + (LOG_IN_W'(1) << FRACTION_BITS)),
		.r   (lden)
	);

	always_ff @(posedge clk) begin
		if (en[ST_MAG])
			mag_s <= (lden > lnum) ? lden - lnum : '0;
	end

	hdrtm_div u_div (
		.clk (clk),
		.en  (en[ST_SRCH0-1:ST_DIV0]),
		.num (DIV_W'({mag_s, 8'h00})),
		.den (den),
		.quo (y)
	);

	hdrtm_search u_search (
		.clk (clk),
		.en  (en[NUM_STAGES-1:ST_SRCH0]),
		.y   (y),
		.k   (k)
	);

	// zero channel flag rides along
	for (genvar i = 0; i < NUM_STAGES; i++) begin : g_zero
		always_ff @(posedge clk) begin
			if (en[i])
				zero_s[i] <= (i == 0) ? (c == '0) : zero_s[(i == 0) ? 0 : i-1];
		end
	end

	assign byte_out = zero_s[NUM_STAGES-1] ? '0 : k;

endmodule

>>> tb/tb_top.sv
// self-checking testbench of the hdr tone map and gamma pixel block
`timescale 1ns / 100ps

module tb_top;
	import hdrtm_pkg::*;

	// one pixel as it enters the block
	typedef struct packed {
		logic [23:0] blue;
		logic [23:0] green;
		logic [23:0] red;
		logic [21:0] index;
	} hdr_pixel_t;

	// one display pixel as it leaves the block
	typedef struct packed {
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [21:0] index;
	} disp_pixel_t;

	localparam int LIMIT_CYCLES = 400000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	hdr_pixel_t  pixel_queue[$];
	disp_pixel_t display_queue[$];
	logic [10:0] gamma_code;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          send_hold;
	int          fail_count;
	int          cycle_count;

	hdr_tone_map_gamma_pixel_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),   // pixel_index, red_in, green_in, blue_in
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)    // pixel_index_out, red_out, green_out, blue_out
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// log2 in Q.24 by repeated squaring of a Q1.30 mantissa
	function automatic logic [63:0] log2_fixed(input logic [63:0] x);
		logic [63:0] m;
		logic [63:0] r;
		int          pos;
		pos = 0;
		for (int b = 0; b < 64; b++)
			if (x[b]) pos = b;
		if (pos <= MANT_BITS)
			m = x << (MANT_BITS - pos);
		else
			m = x >> (pos - MANT_BITS);
		r = 64'(pos) << LOG_FRAC;
		for (int i = LOG_FRAC - 1; i >= 0; i--) begin
			m = (m * m) >> MANT_BITS;
			if (m >= (64'd2 << MANT_BITS)) begin
				m = m >> 1;
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	// reinhard map, gamma exponent and byte search of one channel
	function automatic logic [7:0] tone_byte(input logic [23:0] c, input logic [10:0] g);
		logic [63:0] lnum;
		logic [63:0] lden;
		logic [63:0] mag;
		logic [63:0] y;
		logic [63:0] lim;
		logic [7:0]  k;
		logic [7:0]  cand;
		logic [63:0] gd;
		if (c == 0) return 8'd0;
		gd   = (g == 0) ? 64'd1 : 64'(g);
		lnum = log2_fixed(64'(c));
		lden = log2_fixed(64'(c) + (64'd1 << FRACTION_BITS));
		mag  = (lden > lnum) ? lden - lnum : 64'd0;
		y    = (mag * 256) / gd;
		lim  = log2_fixed(64'd255);
		k    = 8'd0;
		for (int b = 7; b >= 0; b--) begin
			cand    = k;
			cand[b] = 1'b1;
			if (log2_fixed(64'(cand)) + y <= lim) k = cand;
		end
		return k;
	endfunction

	function automatic disp_pixel_t tone_map_pixel(input hdr_pixel_t p, input logic [10:0] g);
		disp_pixel_t d;
		d.index = p.index;
		d.red   = tone_byte(p.red, g);
		d.green = tone_byte(p.green, g);
		d.blue  = tone_byte(p.blue, g);
		return d;
	endfunction

	// channel values spread over the whole range, most of them at or below 16.0
	function automatic logic [23:0] rand_channel();
		case ($urandom_range(0, 5))
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 255));
			2: return 24'($urandom_range(0, 24'h3_0000));
			3: return 24'hFF_FFFF - 24'($urandom_range(0, 15));
			default: return 24'($urandom_range(0, 24'h10_0000));
		endcase
	endfunction

	// driver: the stream side advances on each transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (pixel_queue.size() != 0 && !send_hold &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {2'b00, pixel_queue[0]};
					display_queue.push_back(tone_map_pixel(pixel_queue[0], gamma_code));
					void'(pixel_queue.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// monitor: compare each output transfer with the oldest expected pixel
	always @(posedge clk) begin
		disp_pixel_t got;
		disp_pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[45:0];
			if (display_queue.size() == 0) begin
				$error("output transfer with nothing expected: %h", m_tdata);
				fail_count++;
			end else begin
				want = display_queue.pop_front();
				if (got.index !== want.index) begin
					$error("pixel_index_out: expected %0d, got %0d", want.index, got.index);
					fail_count++;
				end
				if (got.red !== want.red) begin
					$error("red_out: expected %0d, got %0d", want.red, got.red);
					fail_count++;
				end
				if (got.green !== want.green) begin
					$error("green_out: expected %0d, got %0d", want.green, got.green);
					fail_count++;
				end
				if (got.blue !== want.blue) begin
					$error("blue_out: expected %0d, got %0d", want.blue, got.blue);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// wait until every expected pixel has come out, then let the clock run on before the next test
	task automatic drain_pipeline();
		while (pixel_queue.size() != 0 || s_tvalid || display_queue.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_gamma(input logic [10:0] g);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'd0;
		pwdata  <= 32'(g);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		gamma_code = g;
	endtask

	task automatic push_pixel(input logic [23:0] r, input logic [23:0] g, input logic [23:0] b);
		hdr_pixel_t p;
		p.index = 22'($urandom);
		p.red   = r;
		p.green = g;
		p.blue  = b;
		pixel_queue.push_back(p);
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++)
			push_pixel(rand_channel(), rand_channel(), rand_channel());
	endtask

	logic [10:0] gamma_list[8] = '{11'd563, 11'd64, 11'd2047, 11'd0, 11'd1, 11'd256,
		11'd1024, 11'd300};

	initial begin
		hdr_pixel_t p;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		m_tready      = 1'b0;
		gamma_code    = GAMMA_RESET;
		send_idle_pct = 32;
		recv_idle_pct = 62;
		send_hold     = 1'b0;
		fail_count    = 0;
		cycle_count   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pixels at the reset gamma: zero, extremes, near one
		push_pixel(24'd0, 24'd0, 24'd0);
		push_pixel(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
		push_pixel(24'd1, 24'h01_0000, 24'hFF_FFFF);
		push_pixel(24'h00_FFFF, 24'h01_0001, 24'h80_0000);
		push_pixel(24'h55_5555, 24'hAA_AAAA, 24'd2);
		p.index = 22'h3F_FFFF; p.red = 24'd100; p.green = 24'd0; p.blue = 24'h12_3456;
		pixel_queue.push_back(p);
		p.index = 22'd0; p.red = 24'h00_8000; p.green = 24'h04_0000; p.blue = 24'h00_0100;
		pixel_queue.push_back(p);
		drain_pipeline();

		// gamma settings, extremes and zero among them
		foreach (gamma_list[j]) begin
			write_gamma(gamma_list[j]);
			push_pixel(24'd1, 24'hFF_FFFF, 24'h01_0000);
			case (j)
				2: begin send_idle_pct = 62; recv_idle_pct = 32; end
				5: begin send_idle_pct = 0; recv_idle_pct = 0; end
				default: ;
			endcase
			push_random(60);
			// sender holds off until every pixel is out
			if (j == 3) begin
				while (pixel_queue.size() > 30) @(posedge clk);
				send_hold = 1'b1;
				while (s_tvalid || display_queue.size() != 0) @(posedge clk);
				send_hold = 1'b0;
			end
			drain_pipeline();
			if (j == 7) begin
				write_gamma(11'($urandom_range(64, 2047)));
				push_random(500);
				drain_pipeline();
			end
		end

		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
